@@ design/four_level_page_table_walk_defines.svh @@
// assertion macros for the four-level page table walker
// used by the top level; no other dependencies
`ifndef FOUR_LEVEL_PAGE_TABLE_WALK_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALK_DEFINES_SVH

`ifndef ASSERT_OFF
`define FPW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPW_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FPW_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPW_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ design/fpw_pkg.sv @@
// types and constants of the four-level page table walker
// no dependencies; used by the top level and the entry ram
package fpw_pkg;

	localparam int IDX_W    = 9;
	localparam int ENTRIES  = 512;
	localparam int ENTRY_W  = 64;
	localparam int FRAME_W  = 40;
	localparam int TF_W     = 6;
	localparam int VPN_W    = 36;
	localparam int LIM_W    = 7;
	localparam int IN_W     = 128;
	localparam int OUT_W    = 200;

	localparam int BIT_PRESENT = 0;
	localparam int BIT_LARGE   = 7;
	localparam int FRAME_LO    = 12;
	localparam int FRAME_HI    = 51;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_WALK  = 1'b1;

	localparam logic [1:0] PS_NONE = 2'd0;
	localparam logic [1:0] PS_4K   = 2'd1;
	localparam logic [1:0] PS_2M   = 2'd2;
	localparam logic [1:0] PS_1G   = 2'd3;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_TABLE = 2'd1;
	localparam logic [1:0] ERR_LEAF  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_PUSH
	} state_t;

	typedef enum logic [1:0] {
		LVL_TOP,
		LVL_PTR,
		LVL_DIR,
		LVL_LEAF
	} level_t;

	typedef struct packed {
		logic       finish;
		logic       descend;
		logic       set_table;
		logic       set_leaf;
		logic [1:0] ps;
		logic [1:0] err;
	} step_t;

endpackage

@@ design/four_level_page_table_walk.sv @@
// four-level page table walker: top level with walk sequencer and result register
// depends on fpw_pkg, fpw_entry_ram and four_level_page_table_walk_defines.svh
//
// usage
// - s_* carries one item a beat; s_tuser selects a write (0) or a walk (1)
// - a write stores one 64-bit entry at (table_frame, entry_index); frames at or
//   above FRAMES are dropped; it returns one all-zero result beat
// - a walk reads the entry store once per level, one read a cycle through the
//   single ram read port, whose read data is registered; up to four reads
// - a write or a root out of range goes straight to the result with no read;
//   a new item is taken once the previous result has moved to the output
//   register, so each item is finished before the next one is taken
// - m_* holds each result in an output register; a stalled receiver holds it
//   there while the next item is still accepted and worked on
// - cfg_* writes total_frames at any time the block is idle; cfg_ready is
//   always high
// - arst_n clears control state and sets total_frames to FRAMES capped at 64;
//   the entry store is not cleared and must be written before it is walked
`include "four_level_page_table_walk_defines.svh"

module four_level_page_table_walk #(
	parameter int FRAMES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [6:0]   cfg_data,    // total_frames
	input  logic         s_tvalid,
	output logic         s_tready,
	// table_frame, entry_index, entry_value, root_frame, vpn, zero fill
	input  logic [127:0] s_tdata,
	input  logic [0:0]   s_tuser,     // action
	output logic         m_tvalid,
	input  logic         m_tready,
	// page_frame, size_code, top_index, third_index, second_index, leaf_index,
	// pointer_table_frame, directory_frame, leaf_table_frame, error
	output logic [199:0] m_tdata
);

	localparam int FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int AW    = FW + fpw_pkg::IDX_W;
	localparam int DEPTH = FRAMES * fpw_pkg::ENTRIES;
	localparam logic [fpw_pkg::LIM_W-1:0] LIM_RST =
		fpw_pkg::LIM_W'((FRAMES < 64) ? FRAMES : 64);

	// input fields
	logic                          act;
	logic [fpw_pkg::TF_W-1:0]      tf;
	logic [fpw_pkg::IDX_W-1:0]     eidx;
	logic [fpw_pkg::ENTRY_W-1:0]   evalue;
	logic [fpw_pkg::TF_W-1:0]      root;
	logic [fpw_pkg::VPN_W-1:0]     vp;

	assign act    = s_tuser[0];
	assign tf     = s_tdata[5:0];
	assign eidx   = s_tdata[14:6];
	assign evalue = s_tdata[78:15];
	assign root   = s_tdata[84:79];
	assign vp     = s_tdata[120:85];

	fpw_pkg::state_t state_q, state_d;
	fpw_pkg::level_t lvl_q;
	fpw_pkg::step_t  st;

	logic [fpw_pkg::LIM_W-1:0]   lim_q;
	logic                        m_tvalid_q;
	logic [fpw_pkg::OUT_W-1:0]   m_tdata_q;

	logic [fpw_pkg::FRAME_W-1:0] pf_q, f3_q, f2_q, f1_q;
	logic [1:0]                  ps_q, err_q;
	logic [fpw_pkg::VPN_W-1:0]   vp_q;
	logic                        walk_q;

	logic                        s_acc, out_free, root_oor, tf_ok;
	logic                        ram_we, ram_re;
	logic [AW-1:0]               ram_waddr, ram_raddr;
	logic [fpw_pkg::ENTRY_W-1:0] ram_rdata;

	logic                        e_present, e_large, fr_oor;
	logic [fpw_pkg::FRAME_W-1:0] fr;
	logic [fpw_pkg::IDX_W-1:0]   next_idx;
	fpw_pkg::level_t             next_lvl;

	assign cfg_ready = 1'b1;
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign root_oor  = {1'b0, root} >= lim_q;
	assign tf_ok     = 32'(tf) < FRAMES;

	fpw_entry_ram #(
		.AW    (AW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (evalue),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign ram_waddr = {FW'(tf), eidx};

	// entry decode
	assign e_present = ram_rdata[fpw_pkg::BIT_PRESENT];
	assign e_large   = ram_rdata[fpw_pkg::BIT_LARGE];
	assign fr        = ram_rdata[fpw_pkg::FRAME_HI:fpw_pkg::FRAME_LO];
	assign fr_oor    = fr >= fpw_pkg::FRAME_W'(lim_q);

	always_comb begin
		st = '0;
		st.ps  = fpw_pkg::PS_NONE;
		st.err = fpw_pkg::ERR_OK;
		case (lvl_q)
			fpw_pkg::LVL_TOP: begin
				if (!e_present) begin
					st.finish = 1'b1;
				end else begin
					st.set_table = 1'b1;
					if (fr_oor) begin
						st.err    = fpw_pkg::ERR_TABLE;
						st.finish = 1'b1;
					end else begin
						st.descend = 1'b1;
					end
				end
			end
			fpw_pkg::LVL_PTR: begin
				if (e_present && !e_large) begin
					st.set_table = 1'b1;
					if (fr_oor) begin
						st.err    = fpw_pkg::ERR_TABLE;
						st.finish = 1'b1;
					end else begin
						st.descend = 1'b1;
					end
				end else begin
					st.finish = 1'b1;
					if (e_present) begin
						if (fr_oor) begin
							st.err = fpw_pkg::ERR_LEAF;
						end else begin
							st.set_leaf = 1'b1;
							st.ps       = fpw_pkg::PS_1G;
						end
					end
				end
			end
			fpw_pkg::LVL_DIR: begin
				if (e_present && !e_large) begin
					st.set_table = 1'b1;
					if (fr_oor) begin
						st.err    = fpw_pkg::ERR_TABLE;
						st.finish = 1'b1;
					end else begin
						st.descend = 1'b1;
					end
				end else begin
					st.finish = 1'b1;
					if (e_present) begin
						st.set_leaf = 1'b1;
						st.ps       = fpw_pkg::PS_2M;
					end
				end
			end
			fpw_pkg::LVL_LEAF: begin
				st.finish = 1'b1;
				if (e_present) begin
					if (fr_oor) begin
						st.err = fpw_pkg::ERR_LEAF;
					end else begin
						st.set_leaf = 1'b1;
						st.ps       = fpw_pkg::PS_4K;
					end
				end
			end
			default: begin
				st.finish = 1'b1;
			end
		endcase
	end

	// index and level of the next read
	always_comb begin
		case (lvl_q)
			fpw_pkg::LVL_TOP: begin
				next_idx = vp_q[26:18];
				next_lvl = fpw_pkg::LVL_PTR;
			end
			fpw_pkg::LVL_PTR: begin
				next_idx = vp_q[17:9];
				next_lvl = fpw_pkg::LVL_DIR;
			end
			default: begin
				next_idx = vp_q[8:0];
				next_lvl = fpw_pkg::LVL_LEAF;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fpw_pkg::ST_IDLE: begin
				if (s_acc) begin
					if (act == fpw_pkg::ACT_WALK && !root_oor) begin
						state_d = fpw_pkg::ST_LOOK;
					end else begin
						state_d = fpw_pkg::ST_PUSH;
					end
				end
			end
			fpw_pkg::ST_LOOK: begin
				if (st.finish) begin
					state_d = fpw_pkg::ST_PUSH;
				end
			end
			fpw_pkg::ST_PUSH: begin
				if (out_free) begin
					state_d = fpw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fpw_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = {FW'(root), vp[35:27]};
		case (state_q)
			fpw_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				ram_we   = s_tvalid && act == fpw_pkg::ACT_WRITE && tf_ok;
				ram_re   = s_tvalid && act == fpw_pkg::ACT_WALK && !root_oor;
			end
			fpw_pkg::ST_LOOK: begin
				ram_re    = st.descend;
				ram_raddr = {FW'(fr), next_idx};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fpw_pkg::ST_IDLE;
			lvl_q      <= fpw_pkg::LVL_TOP;
			lim_q      <= LIM_RST;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				lim_q <= (32'(cfg_data) < FRAMES) ? cfg_data : fpw_pkg::LIM_W'(FRAMES);
			end
			if (s_acc) begin
				lvl_q <= fpw_pkg::LVL_TOP;
			end else if (state_q == fpw_pkg::ST_LOOK && st.descend) begin
				lvl_q <= next_lvl;
			end
			if (state_q == fpw_pkg::ST_PUSH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// walk results and output beat
	always_ff @(posedge clk) begin
		if (s_acc) begin
			pf_q   <= '0;
			f3_q   <= '0;
			f2_q   <= '0;
			f1_q   <= '0;
			ps_q   <= fpw_pkg::PS_NONE;
			err_q  <= (act == fpw_pkg::ACT_WALK && root_oor) ?
				fpw_pkg::ERR_TABLE : fpw_pkg::ERR_OK;
			vp_q   <= vp;
			walk_q <= act;
		end else if (state_q == fpw_pkg::ST_LOOK) begin
			if (st.set_table) begin
				case (lvl_q)
					fpw_pkg::LVL_TOP: f3_q <= fr;
					fpw_pkg::LVL_PTR: f2_q <= fr;
					default:          f1_q <= fr;
				endcase
			end
			if (st.set_leaf) begin
				pf_q <= fr;
			end
			if (st.finish) begin
				ps_q  <= st.ps;
				err_q <= st.err;
			end
		end
		// indices go out top level lowest
		if (state_q == fpw_pkg::ST_PUSH && out_free) begin
			m_tdata_q <= {err_q, f1_q, f2_q, f3_q,
				walk_q ? {vp_q[8:0], vp_q[17:9], vp_q[26:18], vp_q[35:27]} :
				{fpw_pkg::VPN_W{1'b0}}, ps_q, pf_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`FPW_ASSERT_NEVER(a_no_write_mid_walk, clk, arst_n, ram_we && (state_q != fpw_pkg::ST_IDLE), "entry write outside idle")
	`FPW_ASSERT(a_walk_starts_top, clk, arst_n, (s_acc && act == fpw_pkg::ACT_WALK && !root_oor) |=> (state_q == fpw_pkg::ST_LOOK && lvl_q == fpw_pkg::LVL_TOP), "walk did not start at top level")
	`FPW_ASSERT_NEVER(a_err_no_size, clk, arst_n, m_tvalid && (m_tdata[199:198] != fpw_pkg::ERR_OK) && (m_tdata[41:40] != fpw_pkg::PS_NONE), "error result with page size")
	`FPW_ASSERT(a_push_lands, clk, arst_n, (state_q == fpw_pkg::ST_PUSH && out_free) |=> m_tvalid, "result not moved to output")

endmodule

@@ design/fpw_entry_ram.sv @@
// entry store of the page table walker: one write port, one registered read port
// depends on fpw_pkg for the entry width
module fpw_entry_ram #(
	parameter int AW    = 15,
	parameter int DEPTH = 32768
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [fpw_pkg::ENTRY_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [fpw_pkg::ENTRY_W-1:0] rdata
);

	logic [fpw_pkg::ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ test/testbench.sv @@
// testbench for four_level_page_table_walk: drives write and walk beats, predicts each result
// from its own copy of the entry store and frame limit, and checks every result beat
// depends on fpw_pkg and four_level_page_table_walk
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLES      = 64;
	localparam int RUN_LIMIT   = 1000000;
	localparam int PHASE_BEATS = 165;
	localparam int HOLD_CYCLES = 250;

	// s_tdata fields, highest first
	typedef struct packed {
		logic [6:0]                  fill;
		logic [fpw_pkg::VPN_W-1:0]   vpn;
		logic [fpw_pkg::TF_W-1:0]    root_frame;
		logic [fpw_pkg::ENTRY_W-1:0] entry_value;
		logic [fpw_pkg::IDX_W-1:0]   entry_index;
		logic [fpw_pkg::TF_W-1:0]    table_frame;
	} item_t;

	// m_tdata fields, highest first
	typedef struct packed {
		logic [1:0]                  error;
		logic [fpw_pkg::FRAME_W-1:0] leaf_table_frame;
		logic [fpw_pkg::FRAME_W-1:0] directory_frame;
		logic [fpw_pkg::FRAME_W-1:0] pointer_table_frame;
		logic [fpw_pkg::IDX_W-1:0]   leaf_index;
		logic [fpw_pkg::IDX_W-1:0]   second_index;
		logic [fpw_pkg::IDX_W-1:0]   third_index;
		logic [fpw_pkg::IDX_W-1:0]   top_index;
		logic [1:0]                  size_code;
		logic [fpw_pkg::FRAME_W-1:0] page_frame;
	} walk_t;

	class translation_checker;
		logic [fpw_pkg::ENTRY_W-1:0] entry_mem [TABLES*fpw_pkg::ENTRIES];
		bit                          entry_set [TABLES*fpw_pkg::ENTRIES];
		logic [fpw_pkg::LIM_W-1:0]   frame_limit;
		walk_t                       walks_due [$];
		int                          first_gap;
		int                          failures;

		function new();
			frame_limit = 7'd64;
			failures = 0;
			first_gap = -1;
		endfunction

		function logic [fpw_pkg::LIM_W-1:0] usable_frames();
			return (frame_limit > TABLES) ? fpw_pkg::LIM_W'(TABLES) : frame_limit;
		endfunction

		// notes the first entry a walk would read before it was ever written
		function logic [fpw_pkg::ENTRY_W-1:0] fetch(logic [fpw_pkg::FRAME_W-1:0] tbl,
				logic [fpw_pkg::IDX_W-1:0] idx);
			int slot;
			slot = int'(tbl) * fpw_pkg::ENTRIES + int'(idx);
			if (!entry_set[slot]) begin
				if (first_gap < 0)
					first_gap = slot;
				return '0;
			end
			return entry_mem[slot];
		endfunction

		function walk_t resolve_walk(item_t it);
			walk_t r;
			logic [fpw_pkg::ENTRY_W-1:0] e;
			logic [fpw_pkg::FRAME_W-1:0] f;
			logic [fpw_pkg::LIM_W-1:0] lim;
			r = '0;
			first_gap = -1;
			lim = usable_frames();
			r.top_index = it.vpn[35:27];
			r.third_index = it.vpn[26:18];
			r.second_index = it.vpn[17:9];
			r.leaf_index = it.vpn[8:0];
			if (it.root_frame >= lim) begin
				r.error = fpw_pkg::ERR_TABLE;
				return r;
			end
			e = fetch(fpw_pkg::FRAME_W'(it.root_frame), r.top_index);
			if (!e[fpw_pkg::BIT_PRESENT])
				return r;
			f = e[fpw_pkg::FRAME_HI:fpw_pkg::FRAME_LO];
			r.pointer_table_frame = f;
			if (f >= lim) begin
				r.error = fpw_pkg::ERR_TABLE;
				return r;
			end
			e = fetch(f, r.third_index);
			if (!e[fpw_pkg::BIT_PRESENT])
				return r;
			f = e[fpw_pkg::FRAME_HI:fpw_pkg::FRAME_LO];
			if (e[fpw_pkg::BIT_LARGE]) begin
				if (f >= lim) begin
					r.error = fpw_pkg::ERR_LEAF;
				end else begin
					r.page_frame = f;
					r.size_code = fpw_pkg::PS_1G;
				end
				return r;
			end
			r.directory_frame = f;
			if (f >= lim) begin
				r.error = fpw_pkg::ERR_TABLE;
				return r;
			end
			e = fetch(f, r.second_index);
			if (!e[fpw_pkg::BIT_PRESENT])
				return r;
			f = e[fpw_pkg::FRAME_HI:fpw_pkg::FRAME_LO];
			// 2 MiB leaf frame goes unchecked
			if (e[fpw_pkg::BIT_LARGE]) begin
				r.page_frame = f;
				r.size_code = fpw_pkg::PS_2M;
				return r;
			end
			r.leaf_table_frame = f;
			if (f >= lim) begin
				r.error = fpw_pkg::ERR_TABLE;
				return r;
			end
			e = fetch(f, r.leaf_index);
			if (!e[fpw_pkg::BIT_PRESENT])
				return r;
			f = e[fpw_pkg::FRAME_HI:fpw_pkg::FRAME_LO];
			if (f >= lim) begin
				r.error = fpw_pkg::ERR_LEAF;
			end else begin
				r.page_frame = f;
				r.size_code = fpw_pkg::PS_4K;
			end
			return r;
		endfunction

		function void record_item(logic act, item_t it);
			int slot;
			if (act == fpw_pkg::ACT_WRITE) begin
				slot = int'(it.table_frame) * fpw_pkg::ENTRIES + int'(it.entry_index);
				entry_mem[slot] = it.entry_value;
				entry_set[slot] = 1'b1;
				walks_due.push_back('0);
			end else begin
				walks_due.push_back(resolve_walk(it));
			end
		endfunction

		function void compare(string name, logic [fpw_pkg::FRAME_W-1:0] want,
				logic [fpw_pkg::FRAME_W-1:0] got);
			if (want !== got) begin
				failures++;
				if (failures <= 100)
					$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(walk_t got);
			walk_t want;
			if (walks_due.size() == 0) begin
				failures++;
				if (failures <= 100)
					$display("%0t: result beat expected none got %h", $time, got);
				return;
			end
			want = walks_due.pop_front();
			compare("page_frame", want.page_frame, got.page_frame);
			compare("size_code", want.size_code, got.size_code);
			compare("top_index", want.top_index, got.top_index);
			compare("third_index", want.third_index, got.third_index);
			compare("second_index", want.second_index, got.second_index);
			compare("leaf_index", want.leaf_index, got.leaf_index);
			compare("pointer_table_frame", want.pointer_table_frame, got.pointer_table_frame);
			compare("directory_frame", want.directory_frame, got.directory_frame);
			compare("leaf_table_frame", want.leaf_table_frame, got.leaf_table_frame);
			compare("error", want.error, got.error);
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [6:0]   cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [199:0] m_tdata;

	translation_checker translations = new();
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int beats_sent = 0;
	int cycles = 0;
	int hold_left = 0;
	bit hold_request = 1'b0;

	four_level_page_table_walk #(
		.FRAMES(TABLES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("four_level_page_table_walk: mismatch");
			$finish;
		end
	end

	// result side: check the beat taken at this edge, then pick the next tready
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			translations.check_result(walk_t'(m_tdata));
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic send_beat(input logic act, input item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= it;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		translations.record_item(act, it);
		beats_sent++;
	endtask

	task automatic put_entry(input logic [fpw_pkg::TF_W-1:0] tf,
			input logic [fpw_pkg::IDX_W-1:0] idx, input logic [fpw_pkg::ENTRY_W-1:0] value);
		item_t it;
		it = '0;
		it.table_frame = tf;
		it.entry_index = idx;
		it.entry_value = value;
		it.root_frame = fpw_pkg::TF_W'($urandom_range(TABLES - 1));
		it.vpn = fpw_pkg::VPN_W'({$urandom, $urandom});
		send_beat(fpw_pkg::ACT_WRITE, it);
	endtask

	// fills every entry the walk would read unwritten, then sends the walk
	task automatic walk_page(input logic [fpw_pkg::TF_W-1:0] root,
			input logic [fpw_pkg::VPN_W-1:0] vp);
		item_t it;
		it.fill = '0;
		it.table_frame = fpw_pkg::TF_W'($urandom_range(TABLES - 1));
		it.entry_index = fpw_pkg::IDX_W'($urandom_range(fpw_pkg::ENTRIES - 1));
		it.entry_value = {$urandom, $urandom};
		it.root_frame = root;
		it.vpn = vp;
		void'(translations.resolve_walk(it));
		while (translations.first_gap >= 0) begin
			put_entry(fpw_pkg::TF_W'(translations.first_gap / fpw_pkg::ENTRIES),
				fpw_pkg::IDX_W'(translations.first_gap % fpw_pkg::ENTRIES), random_entry());
			void'(translations.resolve_walk(it));
		end
		send_beat(fpw_pkg::ACT_WALK, it);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (translations.walks_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_frame_limit(input logic [fpw_pkg::LIM_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		translations.frame_limit = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [fpw_pkg::ENTRY_W-1:0] pte(input bit present, input bit big,
			input logic [fpw_pkg::FRAME_W-1:0] frame);
		logic [fpw_pkg::ENTRY_W-1:0] e;
		e = '0;
		e[fpw_pkg::FRAME_HI:fpw_pkg::FRAME_LO] = frame;
		e[fpw_pkg::BIT_PRESENT] = present;
		e[fpw_pkg::BIT_LARGE] = big;
		return e;
	endfunction

	// frames mostly in range so walks go deep, some just around the limit
	function automatic logic [fpw_pkg::ENTRY_W-1:0] random_entry();
		logic [fpw_pkg::ENTRY_W-1:0] e;
		logic [fpw_pkg::LIM_W-1:0] lim;
		int pick;
		e = {$urandom, $urandom};
		lim = translations.usable_frames();
		pick = $urandom_range(99);
		if (pick < 60 && lim != 0)
			e[fpw_pkg::FRAME_HI:fpw_pkg::FRAME_LO] = fpw_pkg::FRAME_W'($urandom_range(lim - 1));
		else if (pick < 75)
			e[fpw_pkg::FRAME_HI:fpw_pkg::FRAME_LO] =
				fpw_pkg::FRAME_W'($urandom_range(TABLES - 1));
		else if (pick < 87)
			e[fpw_pkg::FRAME_HI:fpw_pkg::FRAME_LO] = fpw_pkg::FRAME_W'(lim) +
				fpw_pkg::FRAME_W'($urandom_range(2)) - 1'b1;
		e[fpw_pkg::BIT_PRESENT] = ($urandom_range(99) < 88);
		e[fpw_pkg::BIT_LARGE] = ($urandom_range(99) < 25);
		return e;
	endfunction

	function automatic logic [fpw_pkg::IDX_W-1:0] random_index();
		if ($urandom_range(99) < 70)
			return fpw_pkg::IDX_W'($urandom_range(3));
		return fpw_pkg::IDX_W'($urandom_range(fpw_pkg::ENTRIES - 1));
	endfunction

	function automatic logic [fpw_pkg::VPN_W-1:0] random_page();
		if ($urandom_range(9) == 0)
			return fpw_pkg::VPN_W'({$urandom, $urandom});
		return {random_index(), random_index(), random_index(), random_index()};
	endfunction

	function automatic logic [fpw_pkg::TF_W-1:0] random_root();
		logic [fpw_pkg::LIM_W-1:0] lim;
		lim = translations.usable_frames();
		if (lim != 0 && $urandom_range(99) < 75)
			return fpw_pkg::TF_W'($urandom_range(lim - 1));
		return fpw_pkg::TF_W'($urandom_range(TABLES - 1));
	endfunction

	initial begin
		logic [fpw_pkg::LIM_W-1:0] phase_limits [8];
		int mode;
		bit held;
		bit paused;
		phase_limits = '{7'd64, 7'd127, 7'd16, 7'd1, 7'd0, 7'd4, 7'd33, 7'd64};
		held = 1'b0;
		paused = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hand-built tables at reset limit: frames 0 to 3 form one chain
		put_entry(0, 0, pte(1, 0, 1));
		put_entry(1, 0, pte(1, 0, 2));
		put_entry(2, 0, pte(1, 0, 3));
		put_entry(3, 0, pte(1, 0, 5));
		put_entry(2, 1, pte(1, 1, 40'hFF_FFFF_FFFF));
		put_entry(1, 1, pte(1, 1, 7));
		put_entry(1, 2, pte(1, 1, 64));
		put_entry(3, 1, pte(1, 0, 100));
		put_entry(3, 2, '0);
		put_entry(0, 1, pte(1, 0, 64));
		put_entry(1, 3, pte(1, 0, 1000));
		put_entry(2, 2, pte(1, 0, 40'hFF_FFFF_FFFF));
		put_entry(0, 2, pte(0, 1, 1));
		put_entry(0, 3, pte(1, 1, 1));
		put_entry(3, 3, pte(1, 1, 6) | 64'hFFF0_0000_0000_0F7E);
		put_entry(63, 511, '1);
		walk_page(0, 36'h0);
		walk_page(0, 36'h200);
		walk_page(0, 36'h40000);
		walk_page(0, 36'h80000);
		walk_page(0, 36'h1);
		walk_page(0, 36'h2);
		walk_page(0, 36'h8000000);
		walk_page(0, 36'hC0000);
		walk_page(0, 36'h400);
		walk_page(0, 36'h10000000);
		walk_page(0, 36'h18000003);
		walk_page(63, '1);
		drain();

		for (int p = 0; p < 8; p++) begin
			mode = p % 4;
			tx_idle_pct = (mode == 1) ? 47 : (mode == 3) ? 30 : 0;
			rx_stall_pct = (mode == 2) ? 47 : (mode == 3) ? 30 : 0;
			set_frame_limit(phase_limits[p]);
			beats_sent = 0;
			while (beats_sent < PHASE_BEATS) begin
				// long receiver hold-off while beats keep coming
				if (p == 2 && !held && beats_sent >= 80) begin
					hold_request = 1'b1;
					held = 1'b1;
				end
				if (p == 3 && !paused && beats_sent >= 80) begin
					drain();
					paused = 1'b1;
				end
				if ($urandom_range(99) < 15)
					put_entry(fpw_pkg::TF_W'($urandom_range(TABLES - 1)), random_index(),
						$urandom_range(1) ? random_entry() : {$urandom, $urandom});
				else
					walk_page(random_root(), random_page());
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (translations.failures == 0 && translations.walks_due.size() == 0) begin
			$display("four_level_page_table_walk: match");
		end else begin
			$display("four_level_page_table_walk: mismatch");
		end
		$finish;
	end
endmodule
